// ----- src/mer_pkg.sv -----
// shared constants, codes and controller/datapath handshake types for the ellipse rasterizer
package mer_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int CTR_W           = 11;
  localparam int RAD_W           = 10;
  localparam int PT_W            = 12;

  // item kind codes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_RXRX,
    MUL_RYRY,
    MUL_RX2RY,
    MUL_AA,
    MUL_RY2P,
    MUL_BB,
    MUL_RX2P,
    MUL_RX2RY2
  } mer_mul_t;

  // datapath register update ops
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SAVE_RX2,
    OP_SAVE_RY2,
    OP_START,
    OP_STEP,
    OP_STEP_DEC,
    OP_CLOSE,
    OP_ACC_LOAD,
    OP_ACC_ADD,
    OP_R2_SET
  } mer_op_t;

  typedef struct packed {
    logic       load_geom;
    mer_mul_t   mul;
    mer_op_t    op;
    logic [1:0] quad;
  } mer_cmd_t;

  typedef struct packed {
    logic need_r2;
    logic active;
  } mer_status_t;

endpackage

// ----- src/mer_in_if.sv -----
// input item channel: start or step request with centre and radii
interface mer_in_if;
  import mer_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [CTR_W-1:0] center_x;
  logic signed [CTR_W-1:0] center_y;
  logic [RAD_W-1:0]        x_radius;
  logic [RAD_W-1:0]        y_radius;

  modport source (
    output valid, kind, center_x, center_y, x_radius, y_radius,
    input  ready
  );

  modport sink (
    input  valid, kind, center_x, center_y, x_radius, y_radius,
    output ready
  );

endinterface

// ----- src/mer_out_if.sv -----
// result item channel: one plotted point with step flags
interface mer_out_if;
  import mer_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic                   last_of_step;
  logic                   finished;

  modport source (
    output valid, point_x, point_y, last_of_step, finished,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, last_of_step, finished,
    output ready
  );

endinterface

// ----- src/midpoint_ellipse_rasterizer.sv -----
// midpoint ellipse rasterizer top level: handshake channels around controller and datapath
// start item: busy through the init states, and the region two states when it opens there; no result
// step item: four points after the STEP2 and CHK states, one point per cycle while the sink is ready
// the step that enters region two also runs the region two setup states before its points
// a new item waits for the decision update, the region check and all four points of the last
// a step while no ellipse is active is taken while idle, leaves the block idle and gives no result
// synchronous active-low reset: no ellipse active, region one, position and slopes cleared
module midpoint_ellipse_rasterizer #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  mer_in_if.sink           in_item,
  mer_out_if.source        out_item
);
  import mer_pkg::*;

  // command and status between the sequencer and the arithmetic
  mer_cmd_t    cmd;
  mer_status_t st;

  // sequencer: one item at a time, ready only when idle
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_kind   (in_item.kind),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: geometry, squared radii, slopes, decision and the point adders
  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_center_x  (in_item.center_x),
    .in_center_y  (in_item.center_y),
    .in_x_radius  (in_item.x_radius),
    .in_y_radius  (in_item.y_radius),
    .cmd          (cmd),
    .st           (st),
    .point_x      (out_item.point_x),
    .point_y      (out_item.point_y),
    .last_of_step (out_item.last_of_step),
    .finished     (out_item.finished)
  );

endmodule

// ----- src/mer_ctrl.sv -----
// sequencing state machine for the ellipse rasterizer
module mer_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mer_pkg::mer_status_t st,
  output mer_pkg::mer_cmd_t    cmd
);
  import mer_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT0,
    S_INIT1,
    S_INIT2,
    S_INIT3,
    S_STEP2,
    S_CHK,
    S_R2_0,
    S_R2_1,
    S_R2_2,
    S_R2_3,
    S_R2_4,
    S_R2_5,
    S_EMIT0,
    S_EMIT1,
    S_EMIT2,
    S_EMIT3
  } state_t;

  state_t state_r, state_nxt;
  logic   from_step_r, from_step_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT0) || (state_r == S_EMIT1) ||
                     (state_r == S_EMIT2) || (state_r == S_EMIT3);

  always_comb begin
    state_nxt     = state_r;
    from_step_nxt = from_step_r;
    cmd.load_geom = 1'b0;
    cmd.mul       = MUL_AA;
    cmd.op        = OP_NONE;
    cmd.quad      = 2'd0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_START) begin
            cmd.load_geom = 1'b1;
            from_step_nxt = 1'b0;
            state_nxt     = S_INIT0;
          end else if (st.active) begin
            cmd.op        = OP_STEP;
            from_step_nxt = 1'b1;
            state_nxt     = S_STEP2;
          end
        end
      end
      S_INIT0: begin
        cmd.mul   = MUL_RXRX;
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        cmd.mul   = MUL_RYRY;
        cmd.op    = OP_SAVE_RX2;
        state_nxt = S_INIT2;
      end
      S_INIT2: begin
        cmd.mul   = MUL_RX2RY;
        cmd.op    = OP_SAVE_RY2;
        state_nxt = S_INIT3;
      end
      S_INIT3: begin
        cmd.op    = OP_START;
        state_nxt = S_CHK;
      end
      S_STEP2: begin
        cmd.op    = OP_STEP_DEC;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (st.need_r2) begin
          state_nxt = S_R2_0;
        end else begin
          cmd.op    = OP_CLOSE;
          state_nxt = from_step_r ? S_EMIT0 : S_IDLE;
        end
      end
      S_R2_0: begin
        cmd.mul   = MUL_AA;
        state_nxt = S_R2_1;
      end
      S_R2_1: begin
        cmd.mul   = MUL_RY2P;
        state_nxt = S_R2_2;
      end
      S_R2_2: begin
        cmd.mul   = MUL_BB;
        cmd.op    = OP_ACC_LOAD;
        state_nxt = S_R2_3;
      end
      S_R2_3: begin
        cmd.mul   = MUL_RX2P;
        state_nxt = S_R2_4;
      end
      S_R2_4: begin
        cmd.mul   = MUL_RX2RY2;
        cmd.op    = OP_ACC_ADD;
        state_nxt = S_R2_5;
      end
      S_R2_5: begin
        cmd.op    = OP_R2_SET;
        state_nxt = S_CHK;
      end
      S_EMIT0: begin
        cmd.quad = 2'd0;
        if (out_ready) state_nxt = S_EMIT1;
      end
      S_EMIT1: begin
        cmd.quad = 2'd1;
        if (out_ready) state_nxt = S_EMIT2;
      end
      S_EMIT2: begin
        cmd.quad = 2'd2;
        if (out_ready) state_nxt = S_EMIT3;
      end
      S_EMIT3: begin
        cmd.quad = 2'd3;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      from_step_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_step_r <= from_step_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a point is pending");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid && in_kind == KIND_STEP && !st.active) |=> in_ready)
    else $error("step on an inactive ellipse left idle");

  a_last_point_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT3 && out_ready) |=> (in_ready && !out_valid))
    else $error("no return to idle after the fourth point");

endmodule

// ----- src/mer_datapath.sv -----
// position, slope and decision registers with a shared multiplier
module mer_datapath #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [mer_pkg::CTR_W-1:0] in_center_x,
  input  logic signed [mer_pkg::CTR_W-1:0] in_center_y,
  input  logic [mer_pkg::RAD_W-1:0]        in_x_radius,
  input  logic [mer_pkg::RAD_W-1:0]        in_y_radius,
  input  mer_pkg::mer_cmd_t                cmd,
  output mer_pkg::mer_status_t             st,
  output logic signed [mer_pkg::PT_W-1:0]  point_x,
  output logic signed [mer_pkg::PT_W-1:0]  point_y,
  output logic                             last_of_step,
  output logic                             finished
);
  import mer_pkg::*;

  localparam int RW  = RADIUS_BITS;
  localparam int SQW = 2 * RW;
  localparam int SW  = 3 * RW + 4;
  localparam int DW  = 4 * RW + 8;
  localparam int PXW = RW + 1;
  localparam int PYW = RW + 2;
  localparam int MW  = 2 * RW + 6;
  localparam int PW  = 2 * MW;

  logic signed [CTR_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RW-1:0]           rx_r, rx_nxt, ry_r, ry_nxt;
  logic [SQW-1:0]          rx2_r, rx2_nxt, ry2_r, ry2_nxt;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic signed [DW-1:0]    acc_r, acc_nxt;
  logic [PXW-1:0]          pos_x_r, pos_x_nxt, ex_r, ex_nxt;
  logic signed [PYW-1:0]   pos_y_r, pos_y_nxt, ey_r, ey_nxt;
  logic signed [SW-1:0]    sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [DW-1:0]    dec_r, dec_nxt;
  logic                    in_r2_r, in_r2_nxt, active_r, active_nxt, br_r, br_nxt;

  logic signed [MW-1:0] opa, opb, a_s, b_s;
  logic signed [SW-1:0] ry2x2_s, rx2x2_s;
  logic signed [DW-1:0] rx2_d, ry2_d, sx_d, sy_d, prod_d, term_d;
  logic [31:0]          px_w, py_w;

  // 2x+1 and y-1 for the region two starting decision
  assign a_s     = $signed(MW'({pos_x_r, 1'b1}));
  assign b_s     = MW'(pos_y_r) - MW'(1);
  assign ry2x2_s = $signed(SW'({ry2_r, 1'b0}));
  assign rx2x2_s = $signed(SW'({rx2_r, 1'b0}));
  assign rx2_d   = $signed(DW'(rx2_r));
  assign ry2_d   = $signed(DW'(ry2_r));
  assign sx_d    = DW'(sx_r);
  assign sy_d    = DW'(sy_r);
  assign prod_d  = DW'(prod_r);

  always_comb begin
    unique case (cmd.mul)
      MUL_RXRX: begin
        opa = $signed(MW'(rx_r));
        opb = $signed(MW'(rx_r));
      end
      MUL_RYRY: begin
        opa = $signed(MW'(ry_r));
        opb = $signed(MW'(ry_r));
      end
      MUL_RX2RY: begin
        opa = $signed(MW'(rx2_r));
        opb = $signed(MW'(ry_r));
      end
      MUL_AA: begin
        opa = a_s;
        opb = a_s;
      end
      MUL_RY2P: begin
        opa = $signed(MW'(ry2_r));
        opb = MW'(prod_r);
      end
      MUL_BB: begin
        opa = b_s;
        opb = b_s;
      end
      MUL_RX2P: begin
        opa = $signed(MW'(rx2_r));
        opb = MW'(prod_r);
      end
      MUL_RX2RY2: begin
        opa = $signed(MW'(rx2_r));
        opb = $signed(MW'(ry2_r));
      end
      default: begin
        opa = a_s;
        opb = a_s;
      end
    endcase
  end

  assign prod_nxt = opa * opb;

  // decision increment for the move taken in the previous cycle
  always_comb begin
    if (!in_r2_r) begin
      term_d = br_r ? (sx_d + ry2_d) : (sx_d - sy_d + ry2_d);
    end else begin
      term_d = br_r ? (rx2_d - sy_d) : (sx_d - sy_d + rx2_d);
    end
  end

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    rx2_nxt    = rx2_r;
    ry2_nxt    = ry2_r;
    acc_nxt    = acc_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    ex_nxt     = ex_r;
    ey_nxt     = ey_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    dec_nxt    = dec_r;
    in_r2_nxt  = in_r2_r;
    active_nxt = active_r;
    br_nxt     = br_r;
    if (cmd.load_geom) begin
      cx_nxt = in_center_x;
      cy_nxt = in_center_y;
      rx_nxt = RW'(32'(in_x_radius));
      ry_nxt = RW'(32'(in_y_radius));
    end
    case (cmd.op)
      OP_SAVE_RX2: rx2_nxt = SQW'(prod_r);
      OP_SAVE_RY2: ry2_nxt = SQW'(prod_r);
      OP_START: begin
        pos_x_nxt  = '0;
        pos_y_nxt  = $signed(PYW'(ry_r));
        sx_nxt     = '0;
        sy_nxt     = SW'(prod_r) <<< 1;
        dec_nxt    = ((ry2_d - prod_d) <<< 2) + rx2_d;
        in_r2_nxt  = 1'b0;
        active_nxt = 1'b1;
      end
      OP_STEP: begin
        ex_nxt = pos_x_r;
        ey_nxt = pos_y_r;
        if (!in_r2_r) begin
          pos_x_nxt = pos_x_r + PXW'(1);
          sx_nxt    = sx_r + ry2x2_s;
          br_nxt    = dec_r[DW-1];
          if (!dec_r[DW-1]) begin
            pos_y_nxt = pos_y_r - PYW'(1);
            sy_nxt    = sy_r - rx2x2_s;
          end
        end else begin
          pos_y_nxt = pos_y_r - PYW'(1);
          sy_nxt    = sy_r - rx2x2_s;
          br_nxt    = (dec_r > 0);
          if (!(dec_r > 0)) begin
            pos_x_nxt = pos_x_r + PXW'(1);
            sx_nxt    = sx_r + ry2x2_s;
          end
        end
      end
      OP_STEP_DEC: dec_nxt = dec_r + (term_d <<< 2);
      OP_CLOSE: begin
        if (in_r2_r && pos_y_r[PYW-1]) active_nxt = 1'b0;
      end
      OP_ACC_LOAD: acc_nxt = prod_d;
      OP_ACC_ADD:  acc_nxt = acc_r + (prod_d <<< 2);
      OP_R2_SET: begin
        dec_nxt   = acc_r - (prod_d <<< 2);
        in_r2_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      in_r2_r  <= 1'b0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      sx_r     <= '0;
      sy_r     <= '0;
      dec_r    <= '0;
    end else begin
      active_r <= active_nxt;
      in_r2_r  <= in_r2_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      sx_r     <= sx_nxt;
      sy_r     <= sy_nxt;
      dec_r    <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    rx2_r  <= rx2_nxt;
    ry2_r  <= ry2_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    ex_r   <= ex_nxt;
    ey_r   <= ey_nxt;
    br_r   <= br_nxt;
  end

  assign st.need_r2 = !in_r2_r && !(sx_r < sy_r);
  assign st.active  = active_r;

  // mirrored point, wrapped to the output width
  assign px_w = $unsigned(32'(cx_r)) + (cmd.quad[0] ? -$unsigned(32'(ex_r)) : 32'(ex_r));
  assign py_w = $unsigned(32'(cy_r)) + (cmd.quad[1] ? -$unsigned(32'(ey_r)) : $unsigned(32'(ey_r)));

  assign point_x      = $signed(px_w[PT_W-1:0]);
  assign point_y      = $signed(py_w[PT_W-1:0]);
  assign last_of_step = (cmd.quad == 2'd3);
  assign finished     = !active_r;

  a_r2_slopes: assert property (@(posedge clk) disable iff (!rst_n)
    in_r2_r |-> !(sx_r < sy_r))
    else $error("region two with slope_x below slope_y");

  a_end_in_r2: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(active_r) && $past(rst_n)) |-> (in_r2_r && pos_y_r[PYW-1]))
    else $error("ellipse ended outside region two");

  a_r1_y_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !in_r2_r |-> !pos_y_r[PYW-1])
    else $error("negative y while still in region one");

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench: random and directed ellipse drawing checked point by point
module tb;
  import mer_pkg::*;

  localparam longint RADIUS_MASK = (longint'(1) << RADIUS_BITS_DEF) - 1;

  // one input item, or a marker that holds the sender until the output drains
  typedef struct {
    bit                      pause;
    logic                    kind;
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic [RAD_W-1:0]        rx;
    logic [RAD_W-1:0]        ry;
  } request_t;

  // one plotted point as it should leave the block
  typedef struct {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   last_pt;
    logic                   fin;
  } point_t;

  // drawing state, decision terms kept scaled by 4 so no fractions remain
  typedef struct {
    bit     active;
    bit     in_r2;
    longint pos_x;
    longint pos_y;
    longint slope_x;
    longint slope_y;
    longint decision;
    longint cx;
    longint cy;
    longint rx;
    longint ry;
  } ellipse_t;

  logic clk;
  logic rst_n;

  mer_in_if  in_if();
  mer_out_if out_if();

  midpoint_ellipse_rasterizer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if.sink),
    .out_item (out_if.source)
  );

  request_t requests[$];
  point_t   expected_points[$];
  point_t   scratch[$];
  ellipse_t pen;    // tracks the block, advanced on each accepted item
  ellipse_t plan;   // tracks the stimulus as it is generated

  bit in_fire;
  bit hold_done;
  int hold_left;
  int errors;
  int items_taken;
  int starts_taken;
  int steps_taken;
  int points_checked;
  int ellipses_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // switch to region two once the slopes cross, stop once y has gone below zero
  function automatic void settle(inout ellipse_t e);
    longint rx2, ry2, a, b;
    rx2 = e.rx * e.rx;
    ry2 = e.ry * e.ry;
    if (!e.in_r2 && !(e.slope_x < e.slope_y)) begin
      a = 2 * e.pos_x + 1;
      b = e.pos_y - 1;
      e.decision = ry2 * a * a + 4 * rx2 * b * b - 4 * rx2 * ry2;
      e.in_r2 = 1'b1;
    end
    if (e.in_r2 && e.pos_y < 0) e.active = 1'b0;
  endfunction

  // apply one item to a drawing state and append the points it plots
  function automatic void trace_step(inout ellipse_t e, input request_t r,
                                     inout point_t pts[$]);
    longint rx2, ry2, x, y;
    bit     fin;
    point_t p;
    if (r.kind == KIND_START) begin
      e.cx = longint'(r.cx);
      e.cy = longint'(r.cy);
      e.rx = longint'(r.rx) & RADIUS_MASK;
      e.ry = longint'(r.ry) & RADIUS_MASK;
      rx2 = e.rx * e.rx;
      ry2 = e.ry * e.ry;
      e.pos_x = 0;
      e.pos_y = e.ry;
      e.slope_x = 0;
      e.slope_y = 2 * rx2 * e.ry;
      e.decision = 4 * (ry2 - rx2 * e.ry) + rx2;
      e.in_r2 = 1'b0;
      e.active = 1'b1;
      settle(e);
      return;
    end
    // a step with nothing being drawn is dropped
    if (!e.active) return;
    rx2 = e.rx * e.rx;
    ry2 = e.ry * e.ry;
    x = e.pos_x;
    y = e.pos_y;
    if (!e.in_r2) begin
      e.pos_x += 1;
      e.slope_x += 2 * ry2;
      if (e.decision < 0) begin
        e.decision += 4 * (e.slope_x + ry2);
      end else begin
        e.pos_y -= 1;
        e.slope_y -= 2 * rx2;
        e.decision += 4 * (e.slope_x - e.slope_y + ry2);
      end
    end else begin
      e.pos_y -= 1;
      e.slope_y -= 2 * rx2;
      if (e.decision > 0) begin
        e.decision += 4 * (rx2 - e.slope_y);
      end else begin
        e.pos_x += 1;
        e.slope_x += 2 * ry2;
        e.decision += 4 * (e.slope_x - e.slope_y + rx2);
      end
    end
    settle(e);
    fin = !e.active;
    // quadrant order: bit 0 mirrors x, bit 1 mirrors y
    for (int q = 0; q < 4; q++) begin
      p.px = PT_W'(q[0] ? e.cx - x : e.cx + x);
      p.py = PT_W'(q[1] ? e.cy - y : e.cy + y);
      p.last_pt = (q == 3);
      p.fin = fin;
      pts.push_back(p);
    end
  endfunction

  // append an item; returns 0 for a step the block will simply ignore
  function automatic bit queue_item(logic kind, int cx, int cy, int rx, int ry);
    request_t r;
    bit       counts;
    r.pause = 1'b0;
    r.kind = kind;
    r.cx = CTR_W'(cx);
    r.cy = CTR_W'(cy);
    r.rx = RAD_W'(rx);
    r.ry = RAD_W'(ry);
    counts = !(kind == KIND_STEP && !plan.active);
    requests.push_back(r);
    trace_step(plan, r, scratch);
    scratch.delete();
    return counts;
  endfunction

  // step payload is don't-care, so it carries random bits
  function automatic int queue_steps(int n);
    int taken;
    taken = 0;
    for (int k = 0; k < n; k++)
      taken += int'(queue_item(KIND_STEP, $urandom, $urandom, $urandom, $urandom));
    return taken;
  endfunction

  function automatic int queue_to_end();
    int taken;
    taken = 0;
    while (plan.active)
      taken += int'(queue_item(KIND_STEP, $urandom, $urandom, $urandom, $urandom));
    return taken;
  endfunction

  function automatic void queue_pause();
    request_t r;
    r = '{default: '0};
    r.pause = 1'b1;
    requests.push_back(r);
  endfunction

  // sender: presents the head of the request queue at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_fire)) begin
      // a pause marker waits for every outstanding point
      if (requests.size() != 0 && requests[0].pause && expected_points.size() == 0)
        requests.delete(0);
      if (requests.size() == 0 || requests[0].pause ||
          (!(items_taken >= 60 && items_taken < 100) && $urandom_range(99) < 36)) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid    <= 1'b1;
        in_if.kind     <= requests[0].kind;
        in_if.center_x <= requests[0].cx;
        in_if.center_y <= requests[0].cy;
        in_if.x_radius <= requests[0].rx;
        in_if.y_radius <= requests[0].ry;
      end
    end
  end

  // receiver: random stalls, one long hold-off, and a stretch always ready
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && points_checked >= 100) begin
      out_if.ready <= 1'b0;
      hold_left <= 250;
      hold_done <= 1'b1;
    end else if (points_checked >= 200 && points_checked < 320) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 36);
    end
  end

  // both channels sampled at the rising edge: results checked, then new items traced
  always @(posedge clk) begin : watch
    point_t   want;
    request_t req;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: point with none expected: x %0d y %0d last %0b fin %0b", $time,
                   out_if.point_x, out_if.point_y, out_if.last_of_step, out_if.finished);
          errors++;
        end else begin
          want = expected_points.pop_front();
          if (out_if.point_x !== want.px) begin
            $display("%0t: point_x expected %0d actual %0d", $time, want.px, out_if.point_x);
            errors++;
          end
          if (out_if.point_y !== want.py) begin
            $display("%0t: point_y expected %0d actual %0d", $time, want.py, out_if.point_y);
            errors++;
          end
          if (out_if.last_of_step !== want.last_pt) begin
            $display("%0t: last_of_step expected %0b actual %0b", $time, want.last_pt,
                     out_if.last_of_step);
            errors++;
          end
          if (out_if.finished !== want.fin) begin
            $display("%0t: finished expected %0b actual %0b", $time, want.fin,
                     out_if.finished);
            errors++;
          end
          if (want.fin && want.last_pt) ellipses_done++;
        end
        points_checked++;
      end
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        req = requests.pop_front();
        trace_step(pen, req, expected_points);
        items_taken++;
        if (req.kind == KIND_START) starts_taken++;
        else steps_taken++;
      end
    end
  end

  initial begin : stimulus
    int counted;
    int sel;
    int rx;
    int ry;
    bit paused_mid;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_STEP;
    in_if.center_x = '0;
    in_if.center_y = '0;
    in_if.x_radius = '0;
    in_if.y_radius = '0;
    out_if.ready = 1'b0;
    plan = '{default: 0};
    pen = '{default: 0};
    counted = 0;
    paused_mid = 1'b0;

    // directed: step while idle, zero radii, extreme centres and radii,
    // restart in the middle of an ellipse, flat and tall shapes
    void'(queue_steps(1));
    void'(queue_item(KIND_START, -1024, 1023, 0, 0));
    void'(queue_to_end());
    void'(queue_steps(1));
    void'(queue_item(KIND_START, 1023, -1024, 1023, 1023));
    void'(queue_steps(3));
    void'(queue_item(KIND_START, 0, 0, 0, 3));
    void'(queue_to_end());
    void'(queue_item(KIND_START, -5, 7, 5, 0));
    void'(queue_to_end());
    void'(queue_item(KIND_START, 100, -200, 1023, 1));
    void'(queue_steps(2));
    void'(queue_item(KIND_START, -300, 400, 1, 1023));
    void'(queue_steps(1));
    void'(queue_item(KIND_START, 10, 20, 3, 2));
    void'(queue_to_end());
    queue_pause();

    // random: mostly whole small ellipses, some abandoned, some noise
    while (counted < 150) begin
      if (!paused_mid && counted >= 75) begin
        queue_pause();
        paused_mid = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 80) begin
        if ($urandom_range(9) == 0) begin
          // large radii: a few steps, then left for the next start
          counted += int'(queue_item(KIND_START, $urandom, $urandom,
                                     $urandom_range(1023), $urandom_range(1023)));
          counted += queue_steps($urandom_range(1, 6));
        end else begin
          rx = $urandom_range(12);
          ry = $urandom_range(12);
          counted += int'(queue_item(KIND_START, $urandom, $urandom, rx, ry));
          if ($urandom_range(9) < 2) counted += queue_steps($urandom_range(1, 5));
          else counted += queue_to_end();
          if ($urandom_range(9) < 3) counted += queue_steps(1);
        end
      end else begin
        counted += int'(queue_item(($urandom_range(1) == 0) ? KIND_START : KIND_STEP,
                                   $urandom, $urandom, $urandom, $urandom));
      end
    end
    // finish on a small whole ellipse so the run ends on a finished one
    void'(queue_item(KIND_START, 0, 0, 3, 2));
    void'(queue_to_end());

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (requests.size() != 0 || expected_points.size() != 0) @(posedge clk);
    // an ignored step or a start may still be in flight
    repeat (30) @(posedge clk);

    $display("run covered %0d starts and %0d steps, %0d points checked, %0d ellipses closed",
             starts_taken, steps_taken, points_checked, ellipses_done);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d items and %0d points outstanding",
             requests.size(), expected_points.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
src/mer_pkg.sv
src/mer_in_if.sv
src/mer_out_if.sv
src/mer_ctrl.sv
src/mer_datapath.sv
src/midpoint_ellipse_rasterizer.sv
tb/sv/tb.sv
